### sv/deq_pkg.sv
// shared types, codes and constants of the double-ended queue unit
package deq_pkg;

    localparam int DepthDef = 16;
    localparam int OpW      = 3;
    localparam int ValW     = 32;
    localparam int CntW     = 5;
    localparam int StatW    = 2;

    localparam logic [ValW-1:0] EmptyMark = '1;

    typedef enum logic [OpW-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK       = 3'd4
    } t_op;

    typedef enum logic [StatW-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic            load;
        logic            empty;
        logic [CntW-1:0] count;
        t_status         status;
    } t_deq_load;

endpackage

### sv/deq_if.sv
// request and response channel interfaces of the double-ended queue unit
interface deq_req_if
    import deq_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [OpW-1:0]         op;
    logic signed [ValW-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface deq_rsp_if
    import deq_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic signed [ValW-1:0] front_value;
    logic signed [ValW-1:0] back_value;
    logic                   is_empty;
    logic [CntW-1:0]        entry_count;
    logic [StatW-1:0]       status;

    modport source (output valid, output front_value, output back_value,
                    output is_empty, output entry_count, output status, input ready);
    modport sink   (input valid, input front_value, input back_value,
                    input is_empty, input entry_count, input status, output ready);
endinterface

### sv/deq_ram.sv
// generic ram: one write port, two registered read ports
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### sv/deq_ctrl.sv
// head, tail and count registers with the per-request sequencer
module deq_ctrl
    import deq_pkg::*;
#(
    parameter int DEPTH = DepthDef
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_req_valid,
    input  logic [OpW-1:0]           i_req_op,
    input  logic [ValW-1:0]          i_req_value,
    input  logic                     i_out_free,
    output logic                     o_req_ready,
    output logic                     o_we,
    output logic [$clog2(DEPTH)-1:0] o_waddr,
    output logic [ValW-1:0]          o_wdata,
    output logic                     o_re,
    output logic [$clog2(DEPTH)-1:0] o_raddr_a,
    output logic [$clog2(DEPTH)-1:0] o_raddr_b,
    output t_deq_load                o_load
);

    localparam int AddrW = $clog2(DEPTH);
    localparam int OccW  = $clog2(DEPTH + 1);
    localparam logic [AddrW-1:0] LastIdx = AddrW'(DEPTH - 1);
    localparam logic [OccW-1:0]  FullOcc = OccW'(DEPTH);

    function automatic logic [AddrW-1:0] idx_inc(input logic [AddrW-1:0] i);
        return (i == LastIdx) ? '0 : i + AddrW'(1);
    endfunction

    function automatic logic [AddrW-1:0] idx_dec(input logic [AddrW-1:0] i);
        return (i == '0) ? LastIdx : i - AddrW'(1);
    endfunction

    t_state          r_state, n_state;
    logic [AddrW-1:0] r_head, n_head;
    logic [AddrW-1:0] r_tail, n_tail;
    logic [OccW-1:0]  r_occ, n_occ;
    t_status          r_status, n_status;
    logic             accept;

    assign accept = i_req_valid && o_req_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_req_valid) n_state = S_READ;
            S_READ: n_state = S_LOAD;
            S_LOAD: if (i_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // index update and slot write on accept
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_occ    = r_occ;
        n_status = r_status;
        o_we     = 1'b0;
        o_waddr  = r_tail;
        o_wdata  = i_req_value;
        if (accept) begin
            n_status = ST_OK;
            unique case (i_req_op)
                OP_PUSH_FRONT: begin
                    if (r_occ == FullOcc) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        n_head  = idx_dec(r_head);
                        o_waddr = idx_dec(r_head);
                        o_we    = 1'b1;
                        n_occ   = r_occ + OccW'(1);
                    end
                end
                OP_PUSH_BACK: begin
                    if (r_occ == FullOcc) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        o_waddr = r_tail;
                        o_we    = 1'b1;
                        n_tail  = idx_inc(r_tail);
                        n_occ   = r_occ + OccW'(1);
                    end
                end
                OP_POP_FRONT: begin
                    if (r_occ == '0) begin
                        n_status = ST_UNDERFLOW;
                    end else begin
                        n_head = idx_inc(r_head);
                        n_occ  = r_occ - OccW'(1);
                    end
                end
                OP_POP_BACK: begin
                    if (r_occ == '0) begin
                        n_status = ST_UNDERFLOW;
                    end else begin
                        n_tail = idx_dec(r_tail);
                        n_occ  = r_occ - OccW'(1);
                    end
                end
                default: n_status = ST_OK;
            endcase
        end
    end

    // outputs of the sequencer
    always_comb begin
        o_req_ready  = (r_state == S_IDLE);
        o_re         = (r_state == S_READ);
        o_raddr_a    = r_head;
        o_raddr_b    = idx_dec(r_tail);
        o_load.load   = (r_state == S_LOAD) && i_out_free;
        o_load.empty  = (r_occ == '0);
        o_load.count  = CntW'(r_occ);
        o_load.status = r_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_occ    <= '0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_occ    <= n_occ;
            r_status <= n_status;
        end
    end

endmodule

### sv/double_ended_queue_unit.sv
// top level of the double-ended queue unit: ring store, sequencer, response register
//
//   channel  | dir | payload                                              | modport
//   ---------+-----+------------------------------------------------------+--------
//   i_req    | in  | op[2:0], value[31:0] signed                          | sink
//   o_rsp    | out | front_value, back_value, is_empty, entry_count,      | source
//            |     | status                                               |
//
// each request steps through the sequencer states in order: accept and slot write, ram read
// of front and back, load of the response register; the single write port and the registered
// ram read set these steps
// a new request is taken while the previous response still waits in o_rsp
// an unaccepted response holds the sequencer in its load step
// synchronous active-low reset empties the queue; slot contents are not cleared
module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int DEPTH = DepthDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    deq_req_if.sink    i_req,
    deq_rsp_if.source  o_rsp
);

    localparam int AddrW = $clog2(DEPTH);

    // ram hookup
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [ValW-1:0]  wdata;
    logic             re;
    logic [AddrW-1:0] raddr_a;
    logic [AddrW-1:0] raddr_b;
    logic [ValW-1:0]  rdata_a;
    logic [ValW-1:0]  rdata_b;
    t_deq_load        load;
    logic             out_free;

    // response register
    logic                   r_valid;
    logic signed [ValW-1:0] r_front;
    logic signed [ValW-1:0] r_back;
    logic                   r_empty;
    logic [CntW-1:0]        r_count;
    logic [StatW-1:0]       r_status;

    // register can take a new response when empty or being drained
    assign out_free = !r_valid || o_rsp.ready;

    deq_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_op    (i_req.op),
        .i_req_value (i_req.value),
        .i_out_free  (out_free),
        .o_req_ready (i_req.ready),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr_a   (raddr_a),
        .o_raddr_b   (raddr_b),
        .o_load      (load)
    );

    // ring store: port a reads the front slot, port b the back slot
    deq_ram #(
        .WIDTH(ValW),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re      (re),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // valid flag of the response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load.load) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload, empty queue reports the all-ones mark at both ends
    always_ff @(posedge i_clk) begin
        if (load.load) begin
            r_front  <= load.empty ? EmptyMark : rdata_a;
            r_back   <= load.empty ? EmptyMark : rdata_b;
            r_empty  <= load.empty;
            r_count  <= load.count;
            r_status <= load.status;
        end
    end

    assign o_rsp.valid       = r_valid;
    assign o_rsp.front_value = r_front;
    assign o_rsp.back_value  = r_back;
    assign o_rsp.is_empty    = r_empty;
    assign o_rsp.entry_count = r_count;
    assign o_rsp.status      = r_status;

endmodule

### sv/deq_chk.sv
// port-level checker of the double-ended queue unit, bound to the top level
module deq_chk
    import deq_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_req_valid,
    input logic                   i_req_ready,
    input logic                   i_rsp_valid,
    input logic                   i_rsp_ready,
    input logic signed [ValW-1:0] i_front_value,
    input logic signed [ValW-1:0] i_back_value,
    input logic                   i_is_empty,
    input logic [CntW-1:0]        i_entry_count,
    input logic [StatW-1:0]       i_status
);

    // stalled response stays valid and holds its front and back values, count and status
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_front_value) && $stable(i_back_value)
            && $stable(i_entry_count) && $stable(i_status))
        else $error("response changed while stalled");

    // empty queue reports the mark on both ends
    a_empty_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_is_empty |->
            i_front_value == EmptyMark && i_back_value == EmptyMark)
        else $error("empty response without the empty mark");

    // a failed pop leaves the queue empty
    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status == ST_UNDERFLOW |-> i_is_empty)
        else $error("underflow reported on a non-empty queue");

    // no response appears the cycle after a request is taken
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !$rose(i_rsp_valid))
        else $error("response appeared too early");

endmodule

bind double_ended_queue_unit deq_chk u_deq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_front_value (o_rsp.front_value),
    .i_back_value  (o_rsp.back_value),
    .i_is_empty    (o_rsp.is_empty),
    .i_entry_count (o_rsp.entry_count),
    .i_status      (o_rsp.status)
);

### tb/double_ended_queue_unit_tb.sv
// self-checking testbench of the double-ended queue unit: directed table, then random traffic
module double_ended_queue_unit_tb
    import deq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int Depth      = DepthDef;
    localparam int ClkPeriod  = 10;
    localparam int RandItems  = 1820;
    localparam int HoldCycles = 90;
    localparam int DrainWait  = 16;
    localparam int ExpSlots   = 8;
    localparam int DirMax     = 64;

    // one response as the block reports it
    typedef struct {
        logic signed [ValW-1:0] front;
        logic signed [ValW-1:0] back;
        logic                   empty;
        logic [CntW-1:0]        count;
        t_status                status;
    } t_queue_view;

    // one row of the directed table; known rows carry a typed-in response
    typedef struct {
        logic [OpW-1:0]         op;
        logic signed [ValW-1:0] value;
        bit                     known;
        t_queue_view            view;
    } t_dir_row;

    // traffic shapes of the random part
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } t_mix;

    logic i_clk;
    logic i_rst_n;

    deq_req_if req_ch ();
    deq_rsp_if rsp_ch ();

    double_ended_queue_unit #(
        .DEPTH(Depth)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // shadow copy of the deque: ring, front slot, slot past the back, occupancy
    logic signed [ValW-1:0] ring_store [Depth];
    int                     front_idx;
    int                     back_next_idx;
    int                     held_cnt;

    // responses still owed by the block, oldest first, as a small ring
    t_queue_view exp_ring [ExpSlots];
    int          exp_wr;
    int          exp_rd;

    // directed table
    t_dir_row dir_rows [DirMax];
    int       dir_count;

    int fail_count;
    int views_checked;
    int burst_left;

    // free-running clock
    initial i_clk = 1'b0;
    always #(ClkPeriod / 2) i_clk = ~i_clk;

    // every input known from time zero, reset held low at the start and released at a falling edge
    initial begin
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op    = '0;
        req_ch.value = '0;
        rsp_ch.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // apply one operation to the shadow deque and return the view that follows it
    function automatic t_queue_view advance_deque(logic [OpW-1:0] op,
                                                  logic signed [ValW-1:0] value);
        t_queue_view v;
        v.status = ST_OK;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (held_cnt >= Depth) begin
                    // full: nothing moves
                    v.status = ST_OVERFLOW;
                end else if (op == OP_PUSH_FRONT) begin
                    front_idx = (front_idx + Depth - 1) % Depth;
                    ring_store[front_idx] = value;
                    held_cnt++;
                end else begin
                    ring_store[back_next_idx] = value;
                    back_next_idx = (back_next_idx + 1) % Depth;
                    held_cnt++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (held_cnt == 0) begin
                    // empty: nothing moves
                    v.status = ST_UNDERFLOW;
                end else if (op == OP_POP_FRONT) begin
                    front_idx = (front_idx + 1) % Depth;
                    held_cnt--;
                end else begin
                    back_next_idx = (back_next_idx + Depth - 1) % Depth;
                    held_cnt--;
                end
            end
            // peek and the unused codes leave the deque alone
            default: ;
        endcase
        if (held_cnt == 0) begin
            v.front = EmptyMark;
            v.back  = EmptyMark;
        end else begin
            v.front = ring_store[front_idx];
            v.back  = ring_store[(back_next_idx + Depth - 1) % Depth];
        end
        v.empty = (held_cnt == 0);
        v.count = held_cnt[CntW-1:0];
        return v;
    endfunction

    function automatic t_queue_view make_view(logic signed [ValW-1:0] front,
                                              logic signed [ValW-1:0] back,
                                              logic empty, int count, t_status status);
        t_queue_view v;
        v.front  = front;
        v.back   = back;
        v.empty  = empty;
        v.count  = count[CntW-1:0];
        v.status = status;
        return v;
    endfunction

    task automatic add_row(logic [OpW-1:0] op, logic signed [ValW-1:0] value,
                           bit known, t_queue_view view);
        t_dir_row r;
        r.op    = op;
        r.value = value;
        r.known = known;
        r.view  = view;
        dir_rows[dir_count] = r;
        dir_count++;
    endtask

    // values lean on the extremes and on the empty marker itself
    function automatic logic signed [ValW-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return -32'sd1;
            3:       return 32'sd0;
            4, 5:    return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    // op choice weighted by the current traffic shape
    function automatic logic [OpW-1:0] pick_op(t_mix mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                if (r < 40)      return OP_PUSH_FRONT;
                else if (r < 80) return OP_PUSH_BACK;
                else if (r < 86) return OP_POP_FRONT;
                else if (r < 92) return OP_POP_BACK;
            end
            MIX_DRAIN: begin
                if (r < 40)      return OP_POP_FRONT;
                else if (r < 80) return OP_POP_BACK;
                else if (r < 86) return OP_PUSH_FRONT;
                else if (r < 92) return OP_PUSH_BACK;
            end
            default: begin
                if (r < 22)      return OP_PUSH_FRONT;
                else if (r < 44) return OP_PUSH_BACK;
                else if (r < 66) return OP_POP_FRONT;
                else if (r < 88) return OP_POP_BACK;
            end
        endcase
        // peek or one of the unused codes
        return OpW'($urandom_range(OP_PEEK, 7));
    endfunction

    // sender: new payload at the falling edge, held until the block takes it
    task automatic offer(logic [OpW-1:0] op, logic signed [ValW-1:0] value,
                         bit known, t_queue_view view);
        t_queue_view predicted;
        @(negedge i_clk);
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.value <= value;
        forever begin
            @(posedge i_clk);
            if (req_ch.ready) break;
        end
        // request taken at this edge: predictor always advances
        predicted = advance_deque(op, value);
        exp_ring[exp_wr % ExpSlots] = known ? view : predicted;
        exp_wr++;
    endtask

    // bursts of random length, random gaps between them
    task automatic send_request(logic [OpW-1:0] op, logic signed [ValW-1:0] value,
                                bit known, t_queue_view view);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                req_ch.valid <= 1'b0;
                req_ch.op    <= OpW'($urandom);
                req_ch.value <= $urandom;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        offer(op, value, known, view);
    endtask

    // receiver: own stall pattern, plus one long hold-off to back the block up
    initial begin : rsp_stall
        int  seg;
        int  mode;
        bit  held;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!held && views_checked >= 200) begin
                @(negedge i_clk);
                rsp_ch.ready <= 1'b0;
                repeat (HoldCycles) @(negedge i_clk);
                held = 1'b1;
            end
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(1, 30);
            repeat (seg) begin
                @(negedge i_clk);
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= ~rsp_ch.ready;
                endcase
            end
        end
    end

    // response checker: every accepted response against the oldest expectation
    always @(posedge i_clk) begin
        t_queue_view want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (exp_wr == exp_rd) begin
                $error("response with no request outstanding");
                fail_count++;
            end else begin
                want = exp_ring[exp_rd % ExpSlots];
                exp_rd++;
                views_checked++;
                if (rsp_ch.front_value !== want.front) begin
                    $error("front_value expected %0d got %0d", want.front, rsp_ch.front_value);
                    fail_count++;
                end
                if (rsp_ch.back_value !== want.back) begin
                    $error("back_value expected %0d got %0d", want.back, rsp_ch.back_value);
                    fail_count++;
                end
                if (rsp_ch.is_empty !== want.empty) begin
                    $error("is_empty expected %0b got %0b", want.empty, rsp_ch.is_empty);
                    fail_count++;
                end
                if (rsp_ch.entry_count !== want.count) begin
                    $error("entry_count expected %0d got %0d", want.count, rsp_ch.entry_count);
                    fail_count++;
                end
                if (rsp_ch.status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, rsp_ch.status);
                    fail_count++;
                end
            end
        end
    end

    // main sequence: directed table, random traffic, drain, verdict
    initial begin : stimulus
        t_queue_view none;
        t_mix        mix;
        int          seg_left;
        int          i;
        fail_count    = 0;
        views_checked = 0;
        burst_left    = 0;
        front_idx     = 0;
        back_next_idx = 0;
        held_cnt      = 0;
        exp_wr        = 0;
        exp_rd        = 0;
        dir_count     = 0;
        none = make_view('0, '0, 1'b0, 0, ST_OK);

        // after reset: empty deque, pops on empty
        add_row(OP_PEEK, 32'sd0, 1, make_view(-1, -1, 1'b1, 0, ST_OK));
        add_row(OP_POP_FRONT, 32'sd5, 1, make_view(-1, -1, 1'b1, 0, ST_UNDERFLOW));
        add_row(OP_POP_BACK, 32'sd0, 1, make_view(-1, -1, 1'b1, 0, ST_UNDERFLOW));
        // value extremes at both ends
        add_row(OP_PUSH_FRONT, 32'sh7fff_ffff, 1,
                make_view(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0, 1, ST_OK));
        add_row(OP_PUSH_BACK, 32'sh8000_0000, 1,
                make_view(32'sh7fff_ffff, 32'sh8000_0000, 1'b0, 2, ST_OK));
        add_row(OP_POP_FRONT, 32'sd0, 1,
                make_view(32'sh8000_0000, 32'sh8000_0000, 1'b0, 1, ST_OK));
        // pop back down to empty clears both ends
        add_row(OP_POP_BACK, 32'sd0, 1, make_view(-1, -1, 1'b1, 0, ST_OK));
        // stored all-ones is told apart from empty by the flag
        add_row(OP_PUSH_BACK, -32'sd1, 1, make_view(-1, -1, 1'b0, 1, ST_OK));
        add_row(OP_PUSH_FRONT, 32'sd0, 1, make_view(0, -1, 1'b0, 2, ST_OK));
        // fill to the brim from both ends
        for (i = 2; i < Depth; i++)
            add_row((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, i * 32'sh1111_1111, 0, none);
        // pushes onto a full deque
        add_row(OP_PUSH_FRONT, 32'sd1, 0, none);
        add_row(OP_PUSH_BACK, 32'sd2, 0, none);
        // unused codes behave as peek
        add_row(3'd5, 32'sh5a5a_5a5a, 0, none);
        add_row(3'd6, 32'sha5a5_a5a5, 0, none);
        add_row(3'd7, 32'sh5a5a_5a5a, 0, none);
        add_row(OP_POP_FRONT, 32'sd0, 0, none);
        add_row(OP_POP_BACK, 32'sd0, 0, none);

        @(posedge i_rst_n);
        for (i = 0; i < dir_count; i++)
            send_request(dir_rows[i].op, dir_rows[i].value, dir_rows[i].known, dir_rows[i].view);

        // random part: stretches of fill, drain or balanced traffic
        seg_left = 0;
        mix      = MIX_BALANCED;
        repeat (RandItems) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(10, 60);
                mix      = t_mix'($urandom_range(MIX_FILL, MIX_BALANCED));
            end
            seg_left--;
            send_request(pick_op(mix), pick_value(), 0, none);
        end

        @(negedge i_clk);
        req_ch.valid <= 1'b0;

        // wait out every owed response, then a few quiet cycles
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("PASS double_ended_queue_unit");
        end else begin
            $display("FAIL double_ended_queue_unit");
        end
        $finish;
    end

    // watchdog on the whole run
    initial begin : watchdog
        #(5_000_000);
        $display("FAIL double_ended_queue_unit");
        $finish;
    end

endmodule
